@@ hdl/xvc_pkg.sv @@
// Package for the virtual JTAG cable shift server.
// Holds beat types, result codes, the job handed to the result sequencer and
// the reply-text builder. No dependencies.
package xvc_pkg;

   localparam int unsigned MAX_BYTES_DEF = 32768;

   // Result kinds.
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_CLOCK = 2'd1;
   localparam logic [1:0] KIND_CLOSE = 2'd2;

   // Job kinds for the result sequencer.
   localparam logic [1:0] JOB_INFO  = 2'd0;
   localparam logic [1:0] JOB_BYTES = 2'd1;
   localparam logic [1:0] JOB_CLOSE = 2'd2;
   localparam logic [1:0] JOB_SHIFT = 2'd3;

   localparam int unsigned INFO_MAX = 21;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
      logic       tdo_bit;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] tx_byte;
      logic       tms;
      logic       tdi;
      logic       last;
   } rsp_type;

   // Everything one input beat makes the sequencer emit.
   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  len;     // byte count for JOB_BYTES
      logic [31:0] data;    // bytes for JOB_BYTES, first byte lowest
      logic [7:0]  tms;
      logic [7:0]  tdi;
      logic [3:0]  nclk;    // clocks in a shift job, 1 to 8
      logic [7:0]  bflag;   // a reply byte follows clock k
      logic [63:0] bval;    // value of the reply byte after clock k
   } job_type;

   // Number of decimal digits of a value.
   function automatic int unsigned dec_digits(int unsigned v);
      int unsigned n;
      int unsigned t;
      n = 1;
      t = v / 10;
      while (t != 0) begin
         n = n + 1;
         t = t / 10;
      end
      return n;
   endfunction

   function automatic int unsigned info_len(int unsigned maxb);
      return 15 + dec_digits(maxb) + 1;
   endfunction

   // Reply to getinfo, byte i at bits [8*i +: 8].
   function automatic logic [8*INFO_MAX-1:0] info_text(int unsigned maxb);
      logic [8*INFO_MAX-1:0] r;
      logic [8*15-1:0]       pre;
      int unsigned           nd;
      int unsigned           v;
      r   = '0;
      // Fixed version prefix of the reply, first character in the top byte.
      pre = {8'h78, 8'h76, 8'h63, 8'h53, 8'h65, 8'h72, 8'h76, 8'h65,
             8'h72, 8'h5f, 8'h76, 8'h31, 8'h2e, 8'h30, 8'h3a};
      nd  = dec_digits(maxb);
      v   = maxb;
      for (int i = 0; i < 15; i++) begin
         r[8*i +: 8] = pre[8*(14-i) +: 8];
      end
      for (int i = 0; i < 6; i++) begin
         if (i < nd) begin
            r[8*(15+nd-1-i) +: 8] = 8'h30 + 8'(v % 10);
            v = v / 10;
         end
      end
      r[8*(15+nd) +: 8] = 8'h0a;
      return r;
   endfunction

endpackage

@@ hdl/xvc_seq.sv @@
// Result sequencer: replays one job as a run of result beats through an
// output register. Depends on xvc_pkg.
module xvc_seq
   import xvc_pkg::*;
#(
   parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  job_type job,
   output logic    free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [8*INFO_MAX-1:0] INFO_TEXT = info_text(MAX_BYTES);
   localparam logic [4:0] INFO_LAST = 5'(info_len(MAX_BYTES) - 1);

   logic    busy_ff, busy_in;
   job_type job_ff, job_in;
   logic [4:0] pos_ff, pos_in;
   logic    sub_ff, sub_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   rsp_type cur;
   logic    cur_last;
   logic    adv;
   logic [2:0] k;

   assign adv = !rsp_valid_ff || rsp_ready;
   assign k   = pos_ff[2:0];

   // Current result of the job in hand.
   always_comb begin
      cur      = '0;
      cur_last = 1'b0;
      case (job_ff.kind)
         JOB_INFO: begin
            cur.kind    = KIND_BYTE;
            cur.tx_byte = INFO_TEXT[8*pos_ff +: 8];
            cur_last    = (pos_ff == INFO_LAST);
         end
         JOB_BYTES: begin
            cur.kind    = KIND_BYTE;
            cur.tx_byte = job_ff.data[8*pos_ff[1:0] +: 8];
            cur_last    = (pos_ff == job_ff.len - 5'd1);
         end
         JOB_SHIFT: begin
            if (sub_ff) begin
               cur.kind    = KIND_BYTE;
               cur.tx_byte = job_ff.bval[8*k +: 8];
               cur_last    = ({1'b0, k} == job_ff.nclk - 4'd1);
            end else begin
               cur.kind = KIND_CLOCK;
               cur.tms  = job_ff.tms[k];
               cur.tdi  = job_ff.tdi[k];
               cur_last = ({1'b0, k} == job_ff.nclk - 4'd1) && !job_ff.bflag[k];
            end
         end
         default: begin
            cur.kind = KIND_CLOSE;
            cur_last = 1'b1;
         end
      endcase
      cur.last = cur_last;
   end

   assign free = !busy_ff || (adv && cur_last);

   // Step through the job and fill the output register.
   always_comb begin
      busy_in      = busy_ff;
      job_in       = job_ff;
      pos_in       = pos_ff;
      sub_in       = sub_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (busy_ff && adv) begin
         rsp_in       = cur;
         rsp_valid_in = 1'b1;
         if (cur_last) begin
            busy_in = 1'b0;
         end else if (job_ff.kind == JOB_SHIFT && !sub_ff && job_ff.bflag[k]) begin
            sub_in = 1'b1;
         end else begin
            sub_in = 1'b0;
            pos_in = pos_ff + 5'd1;
         end
      end
      if (start) begin
         busy_in = 1'b1;
         job_in  = job;
         pos_in  = '0;
         sub_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         sub_ff       <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         sub_ff       <= sub_in;
      end
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hdl/xvc_jtag_shift_server.sv @@
// Virtual JTAG cable shift server: protocol parser, TMS store and TDO packer.
// Results: the job is registered in the result sequencer, then each result in
// its output register, one result per cycle while rsp_ready is high; a TDI
// byte gives its clocks plus loopback reply bytes; xvc_seq sets the rate.
// Reset: synchronous, active high; clears the parser and packer, TMS store is
// not cleared. Depends on xvc_pkg and xvc_seq.
module xvc_jtag_shift_server
   import xvc_pkg::*;
#(
   parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   localparam int unsigned SBW = $clog2(MAX_BYTES * 8 + 1);
   localparam int unsigned BIW = $clog2(MAX_BYTES + 1);
   localparam int unsigned AW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam logic [31:0] MAX_BITS = 32'(MAX_BYTES * 8);

   localparam logic [3:0] PH_CMD0    = 4'd0;
   localparam logic [3:0] PH_CMD1_G  = 4'd1;
   localparam logic [3:0] PH_CMD1_S  = 4'd2;
   localparam logic [3:0] PH_CMD1_X  = 4'd3;
   localparam logic [3:0] PH_LIT_G   = 4'd4;
   localparam logic [3:0] PH_LIT_ST  = 4'd5;
   localparam logic [3:0] PH_LIT_SH  = 4'd6;
   localparam logic [3:0] PH_PERIOD  = 4'd7;
   localparam logic [3:0] PH_COUNT   = 4'd8;
   localparam logic [3:0] PH_TMS     = 4'd9;
   localparam logic [3:0] PH_TDI     = 4'd10;

   logic           loopback_ff;
   logic [3:0]     phase_ff, phase_in;
   logic [2:0]     lp_ff, lp_in;
   logic [31:0]    la_ff, la_in;
   logic [SBW-1:0] sb_ff, sb_in;
   logic [BIW-1:0] bi_ff, bi_in;
   logic [SBW-1:0] bc_ff, bc_in;
   logic [7:0]     tp_ff, tp_in;
   logic [SBW-1:0] tc_ff, tc_in;
   logic           prev_ff, prev_in;

   logic [7:0]     tms_mem [MAX_BYTES];
   logic [7:0]     rd_ff;
   logic           wr_en;

   logic           accept;
   logic           start;
   job_type        job;
   logic           seq_free;

   logic [BIW-1:0] vb;
   logic [SBW-1:0] rem;
   logic [3:0]     nclk;
   logic [7:0]     lit;
   logic [2:0]     lit_len;
   logic [2:0]     lp_inc;
   logic [31:0]    la_or;
   logic [BIW-1:0] bi_inc;
   logic [7:0]     pk;
   logic           pv;
   logic [SBW-1:0] tcn;

   assign req_ready = seq_free;
   assign accept    = req_valid && req_ready;
   assign vb        = BIW'((SBW+1)'(sb_ff) + (SBW+1)'(7) >> 3);
   assign rem       = sb_ff - SBW'({bi_ff, 3'b000});
   assign nclk      = (rem >= SBW'(8)) ? 4'd8 : rem[3:0];
   assign lp_inc    = lp_ff + 3'd1;
   assign la_or     = la_ff | (32'(req_data.rx_byte) << {lp_ff[1:0], 3'b000});
   assign bi_inc    = bi_ff + BIW'(1);

   // Expected literal character for the literal phases.
   always_comb begin
      lit     = 8'h00;
      lit_len = 3'd6;
      case (phase_ff)
         PH_LIT_G: begin
            lit_len = 3'd6;
            case (lp_ff)
               3'd0: lit = "t";
               3'd1: lit = "i";
               3'd2: lit = "n";
               3'd3: lit = "f";
               3'd4: lit = "o";
               default: lit = ":";
            endcase
         end
         PH_LIT_ST: begin
            lit_len = 3'd5;
            case (lp_ff)
               3'd0: lit = "t";
               3'd1: lit = "t";
               3'd2: lit = "c";
               3'd3: lit = "k";
               default: lit = ":";
            endcase
         end
         default: begin
            lit_len = 3'd4;
            case (lp_ff)
               3'd0: lit = "i";
               3'd1: lit = "f";
               3'd2: lit = "t";
               default: lit = ":";
            endcase
         end
      endcase
   end

   // Parser and packer next state, and the job for the accepted beat.
   always_comb begin
      phase_in = phase_ff;
      lp_in    = lp_ff;
      la_in    = la_ff;
      sb_in    = sb_ff;
      bi_in    = bi_ff;
      bc_in    = bc_ff;
      tp_in    = tp_ff;
      tc_in    = tc_ff;
      prev_in  = prev_ff;
      wr_en    = 1'b0;
      start    = 1'b0;
      job      = '0;
      pk       = tp_ff;
      pv       = prev_ff;
      tcn      = tc_ff;
      if (accept && req_data.op) begin
         if (!loopback_ff && tc_ff < bc_ff) begin
            pk    = tp_ff | (8'(req_data.tdo_bit) << tc_ff[2:0]);
            tcn   = tc_ff + SBW'(1);
            tc_in = tcn;
            if (tcn[2:0] == 3'd0 || tcn >= sb_ff) begin
               start      = 1'b1;
               job.kind   = JOB_BYTES;
               job.len    = 5'd1;
               job.data   = 32'(pk);
               tp_in      = 8'h00;
            end else begin
               tp_in = pk;
            end
         end
      end else if (accept) begin
         case (phase_ff)
            PH_CMD0: begin
               phase_in = (req_data.rx_byte == "g") ? PH_CMD1_G :
                          (req_data.rx_byte == "s") ? PH_CMD1_S : PH_CMD1_X;
            end
            PH_CMD1_G, PH_CMD1_S: begin
               lp_in = '0;
               la_in = '0;
               if (req_data.rx_byte == "e") begin
                  phase_in = (phase_ff == PH_CMD1_G) ? PH_LIT_G : PH_LIT_ST;
               end else if (req_data.rx_byte == "h" && phase_ff == PH_CMD1_S) begin
                  phase_in = PH_LIT_SH;
               end else begin
                  phase_in = PH_CMD0;
                  start    = 1'b1;
                  job.kind = JOB_CLOSE;
               end
            end
            PH_LIT_G, PH_LIT_ST, PH_LIT_SH: begin
               if (lp_ff < lit_len && req_data.rx_byte != lit) begin
                  la_in[0] = 1'b1;
               end
               lp_in = lp_inc;
               if (lp_inc >= lit_len) begin
                  if (la_in[0]) begin
                     phase_in = PH_CMD0;
                     start    = 1'b1;
                     job.kind = JOB_CLOSE;
                  end else if (phase_ff == PH_LIT_G) begin
                     phase_in = PH_CMD0;
                     start    = 1'b1;
                     job.kind = JOB_INFO;
                  end else if (phase_ff == PH_LIT_ST) begin
                     phase_in = PH_PERIOD;
                  end else begin
                     phase_in = PH_COUNT;
                  end
                  lp_in = '0;
                  la_in = '0;
               end
            end
            PH_PERIOD: begin
               la_in = la_or;
               lp_in = lp_inc;
               if (lp_inc >= 3'd4) begin
                  start    = 1'b1;
                  job.kind = JOB_BYTES;
                  job.len  = 5'd4;
                  job.data = la_or;
                  phase_in = PH_CMD0;
                  lp_in    = '0;
                  la_in    = '0;
               end
            end
            PH_COUNT: begin
               la_in = la_or;
               lp_in = lp_inc;
               if (lp_inc >= 3'd4) begin
                  lp_in = '0;
                  la_in = '0;
                  if (la_or == 32'd0 || la_or > MAX_BITS) begin
                     phase_in = PH_CMD0;
                     start    = 1'b1;
                     job.kind = JOB_CLOSE;
                  end else begin
                     sb_in    = la_or[SBW-1:0];
                     bi_in    = '0;
                     bc_in    = '0;
                     tc_in    = '0;
                     tp_in    = '0;
                     phase_in = PH_TMS;
                  end
               end
            end
            PH_TMS: begin
               wr_en = 1'b1;
               bi_in = bi_inc;
               if (bi_inc >= vb) begin
                  bi_in    = '0;
                  phase_in = PH_TDI;
               end
            end
            PH_TDI: begin
               start    = 1'b1;
               job.kind = JOB_SHIFT;
               job.tms  = rd_ff;
               job.tdi  = req_data.rx_byte;
               job.nclk = nclk;
               bc_in    = bc_ff + SBW'(nclk);
               // Loopback: each clock packs the previous TDI.
               for (int i = 0; i < 8; i++) begin
                  if (loopback_ff && 4'(i) < nclk) begin
                     pk  = pk | (8'(pv) << tcn[2:0]);
                     tcn = tcn + SBW'(1);
                     pv  = req_data.rx_byte[i];
                     if (tcn[2:0] == 3'd0 || tcn >= sb_ff) begin
                        job.bflag[i]       = 1'b1;
                        job.bval[8*i +: 8] = pk;
                        pk                 = 8'h00;
                     end
                  end
               end
               tc_in   = tcn;
               tp_in   = pk;
               prev_in = pv;
               bi_in   = bi_inc;
               if (bi_inc >= vb) begin
                  bi_in    = '0;
                  phase_in = PH_CMD0;
                  lp_in    = '0;
                  la_in    = '0;
               end
            end
            default: begin
               phase_in = PH_CMD0;
               lp_in    = '0;
               la_in    = '0;
               start    = 1'b1;
               job.kind = JOB_CLOSE;
            end
         endcase
      end
   end

   // TMS store, write-first so a byte written last is seen at once.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tms_mem[bi_ff[AW-1:0]] <= req_data.rx_byte;
      end
      if (wr_en && bi_ff[AW-1:0] == bi_in[AW-1:0]) begin
         rd_ff <= req_data.rx_byte;
      end else begin
         rd_ff <= tms_mem[bi_in[AW-1:0]];
      end
   end

   // Control and parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         loopback_ff <= 1'b0;
         phase_ff    <= PH_CMD0;
         lp_ff       <= '0;
         la_ff       <= '0;
         sb_ff       <= '0;
         bi_ff       <= '0;
         bc_ff       <= '0;
         tp_ff       <= '0;
         tc_ff       <= '0;
         prev_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            loopback_ff <= csr_wr_data;
         end
         phase_ff <= phase_in;
         lp_ff    <= lp_in;
         la_ff    <= la_in;
         sb_ff    <= sb_in;
         bi_ff    <= bi_in;
         bc_ff    <= bc_in;
         tp_ff    <= tp_in;
         tc_ff    <= tc_in;
         prev_ff  <= prev_in;
      end
   end

   xvc_seq #(
      .MAX_BYTES (MAX_BYTES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .job       (job),
      .free      (seq_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
